@@ hdl/lrupr_pkg.sv @@
// Package for the LRU page replacement block: default sizes, counter
// constants and the controller-to-datapath command struct.
// No dependencies.
package lrupr_pkg;

  localparam int FramesDef   = 3;
  localparam int PageBitsDef = 8;

  // Fixed widths of the transaction fields.
  localparam int InPageW = 8;
  localparam int EvictW  = 8;
  localparam int CntW    = 16;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_page;  // capture the referenced page
    logic exec;       // search and update the recency stack, load result
  } lrupr_cmd_t;

endpackage

@@ hdl/lrupr_ctrl.sv @@
// Controller of the LRU page replacement block: two-state sequencer and
// output valid flag. Depends on lrupr_pkg.
module lrupr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lrupr_pkg::lrupr_cmd_t cmd_o
);
  import lrupr_pkg::*;

  localparam logic SIdle = 1'b0;
  localparam logic SExec = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d         = state_q;
    cmd_o.load_page = 1'b0;
    cmd_o.exec      = 1'b0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load_page = 1'b1;
          state_d         = SExec;
        end
      end
      SExec: begin
        // Hold until the output register is free.
        if (slot_free) begin
          cmd_o.exec = 1'b1;
          state_d    = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/lrupr_dp.sv @@
// Datapath of the LRU page replacement block: recency stack, parallel
// page compare, stack shift, saturating counters and result registers.
// Depends on lrupr_pkg.
module lrupr_dp #(
  parameter int Frames   = lrupr_pkg::FramesDef,
  parameter int PageBits = lrupr_pkg::PageBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lrupr_pkg::lrupr_cmd_t         cmd_i,
  input  logic [lrupr_pkg::InPageW-1:0] page_i,
  output logic                          hit_o,
  output logic [lrupr_pkg::EvictW-1:0]  evicted_page_o,
  output logic [lrupr_pkg::CntW-1:0]    fault_count_o,
  output logic [lrupr_pkg::CntW-1:0]    access_count_o
);
  import lrupr_pkg::*;

  localparam int PosW = $clog2(Frames);

  logic [PageBits-1:0]         stack_q [Frames];
  logic [PageBits-1:0]         stack_d [Frames];
  logic [PageBits-1:0]         page_q;
  logic [PageBits+InPageW-1:0] page_wide;
  logic [PageBits+EvictW-1:0]  evict_wide;
  logic                        found;
  logic [PosW-1:0]             pos;
  logic [PosW-1:0]             shift_pos;
  logic [CntW-1:0]             faults_q, accesses_q;
  logic                        hit_q;
  logic [EvictW-1:0]           evicted_q;

  // Zero-extend, then keep the low PageBits bits of the input page.
  assign page_wide  = {{PageBits{1'b0}}, page_i};
  assign evict_wide = {{EvictW{1'b0}}, stack_q[0]};

  // Compare all frames; the highest match is the most recent one.
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = 0; i < Frames; i++) begin
      if (stack_q[i] == page_q) begin
        found = 1'b1;
        pos   = PosW'(i);
      end
    end
  end

  // On a miss the whole stack moves down and the oldest entry drops.
  assign shift_pos = found ? pos : '0;

  always_comb begin
    for (int i = 0; i < Frames - 1; i++) begin
      stack_d[i] = (PosW'(i) >= shift_pos) ? stack_q[i+1] : stack_q[i];
    end
    stack_d[Frames-1] = page_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Frames; i++) begin
        stack_q[i] <= PageBits'(i + 1);
      end
      faults_q   <= '0;
      accesses_q <= '0;
    end else if (cmd_i.exec) begin
      stack_q <= stack_d;
      if (!found && (faults_q != CntMax)) begin
        faults_q <= faults_q + 1'b1;
      end
      if (accesses_q != CntMax) begin
        accesses_q <= accesses_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_page) begin
      page_q <= page_wide[PageBits-1:0];
    end
    if (cmd_i.exec) begin
      hit_q     <= found;
      evicted_q <= found ? '0 : evict_wide[EvictW-1:0];
    end
  end

  assign hit_o          = hit_q;
  assign evicted_page_o = evicted_q;
  assign fault_count_o  = faults_q;
  assign access_count_o = accesses_q;

endmodule

@@ hdl/lru_page_replacement.sv @@
// Top level of the LRU page replacement block: controller and datapath.
// Depends on lrupr_pkg, lrupr_ctrl and lrupr_dp.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-------------------------------
//  request  | in        | in_valid_i / in_ready_o  | page_i
//  result   | out       | out_valid_o / out_ready_i| hit_o, evicted_page_o,
//           |           |                          | fault_count_o, access_count_o
//
// Each reference first captures the page, then, in an update step,
// compares all frames in parallel and shifts the recency stack.
// A new request is taken while the previous result still waits.
// If the result register is still occupied, the update cycle holds until
// it is taken, and no request is accepted meanwhile.
// Reset preloads the stack with pages 1..Frames (page 1 least recent) and
// clears both counters; no clearing pass is needed.
module lru_page_replacement #(
  parameter int Frames   = lrupr_pkg::FramesDef,
  parameter int PageBits = lrupr_pkg::PageBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lrupr_pkg::InPageW-1:0] page_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [lrupr_pkg::EvictW-1:0]  evicted_page_o,
  output logic [lrupr_pkg::CntW-1:0]    fault_count_o,
  output logic [lrupr_pkg::CntW-1:0]    access_count_o
);
  import lrupr_pkg::*;

  lrupr_cmd_t cmd;

  // Sequence each transaction: capture, then update and load the result.
  lrupr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Hold the recency stack, counters and the result payload.
  lrupr_dp #(
    .Frames   (Frames),
    .PageBits (PageBits)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .page_i         (page_i),
    .hit_o          (hit_o),
    .evicted_page_o (evicted_page_o),
    .fault_count_o  (fault_count_o),
    .access_count_o (access_count_o)
  );

endmodule

@@ hdl/lrupr_checker.sv @@
// Port-level assertions for the LRU page replacement block, bound to the
// top level. Depends on lrupr_pkg and lru_page_replacement.
module lrupr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [lrupr_pkg::InPageW-1:0] page_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          hit_o,
  input logic [lrupr_pkg::EvictW-1:0]  evicted_page_o,
  input logic [lrupr_pkg::CntW-1:0]    fault_count_o,
  input logic [lrupr_pkg::CntW-1:0]    access_count_o
);
  import lrupr_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // A stalled result stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(hit_o) && $stable(evicted_page_o)
      && $stable(fault_count_o) && $stable(access_count_o))
    else $error("result payload changed while stalled");

  // One transaction at a time: no request right after an accepted one.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("request accepted while busy");

  // A fresh result must follow an accepted request.
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_acc, 2))
    else $error("result without request");

  // Faults never outnumber references.
  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fault_count_o <= access_count_o)
    else $error("fault count above access count");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for lru_page_replacement. It drives page references, keeps its
// own recency stack and counters, and checks every result transaction field by field.
// Depends on lrupr_pkg and the lru_page_replacement RTL.
module tb_top;
  import lrupr_pkg::*;

  localparam int Frames     = FramesDef;
  localparam int PageBits   = PageBitsDef;
  localparam int LongHold   = 300;    // receiver hold-off while the sender keeps offering
  localparam int QuietLimit = 2000;   // cycles with no transaction on either channel

  typedef logic [PageBits-1:0] frame_page_t;

  // One expected result transaction.
  typedef struct packed {
    logic              hit;
    logic [EvictW-1:0] evicted;
    logic [CntW-1:0]   faults;
    logic [CntW-1:0]   accesses;
  } ref_outcome_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [InPageW-1:0] page_i      = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               hit_o;
  logic [EvictW-1:0]  evicted_page_o;
  logic [CntW-1:0]    fault_count_o;
  logic [CntW-1:0]    access_count_o;

  // Page references waiting to be offered, and results still owed by the block.
  logic [InPageW-1:0] page_backlog[$];
  ref_outcome_t       outcome_q[$];

  // Predicted block state: entry 0 is the least recently used page.
  frame_page_t     lru_stack [Frames];
  logic [CntW-1:0] fault_tally;
  logic [CntW-1:0] access_tally;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit long_hold_req  = 1'b0;
  int hold_left      = 0;
  bit page_taken     = 1'b0;
  int mismatches     = 0;

  lru_page_replacement #(
    .Frames  (Frames),
    .PageBits(PageBits)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .page_i        (page_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .evicted_page_o(evicted_page_o),
    .fault_count_o (fault_count_o),
    .access_count_o(access_count_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  function automatic logic [CntW-1:0] sat_incr(input logic [CntW-1:0] v);
    return (v == CntMax) ? v : v + 1'b1;
  endfunction

  // Advance the predicted stack by one reference and queue the result it owes.
  task automatic predict_reference(input logic [InPageW-1:0] pg_in);
    frame_page_t  pg;
    int           pos;
    int           i;
    ref_outcome_t r;
    pg  = frame_page_t'(pg_in);
    pos = -1;
    // Search from the most recent end so a duplicate resolves to the newest copy.
    for (i = Frames - 1; i >= 0; i--) begin
      if (pos < 0 && lru_stack[i] == pg) pos = i;
    end
    r.hit     = (pos >= 0);
    r.evicted = '0;
    if (pos < 0) begin
      // Fault: drop the least recent page and shift the rest toward the old end.
      r.evicted   = EvictW'(lru_stack[0]);
      pos         = 0;
      fault_tally = sat_incr(fault_tally);
    end
    for (i = pos; i < Frames - 1; i++) lru_stack[i] = lru_stack[i + 1];
    lru_stack[Frames - 1] = pg;
    access_tally = sat_incr(access_tally);
    r.faults     = fault_tally;
    r.accesses   = access_tally;
    outcome_q.push_back(r);
  endtask

  task automatic check_outcome();
    ref_outcome_t want;
    if (outcome_q.size() == 0) begin
      flag_mismatch($sformatf("result with no reference pending: hit %0b evicted %0d",
                              hit_o, evicted_page_o));
    end else begin
      want = outcome_q.pop_front();
      if (hit_o !== want.hit)
        flag_mismatch($sformatf("hit got %0b expected %0b", hit_o, want.hit));
      if (evicted_page_o !== want.evicted)
        flag_mismatch($sformatf("evicted_page got %0d expected %0d",
                                evicted_page_o, want.evicted));
      if (fault_count_o !== want.faults)
        flag_mismatch($sformatf("fault_count got %0d expected %0d",
                                fault_count_o, want.faults));
      if (access_count_o !== want.accesses)
        flag_mismatch($sformatf("access_count got %0d expected %0d",
                                access_count_o, want.accesses));
    end
  endtask

  // Monitor: sample both channels at the rising edge. Record an accepted request
  // first so a result in the same cycle still finds its expectation in order.
  always @(posedge clk_i) begin
    page_taken = rst_ni && in_valid_i && in_ready_o;
    if (page_taken) predict_reference(page_i);
    if (rst_ni && out_valid_o && out_ready_i) check_outcome();
  end

  // Driver: at the falling edge, hold the current request until it is taken,
  // then either offer the next page or idle.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || page_taken) begin
      if (page_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        page_i     <= page_backlog.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request so the block backs up.
  always @(negedge clk_i) begin
    if (long_hold_req) begin
      hold_left     = LongHold;
      long_hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Watchdog: give up when neither channel moves a transaction for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("lru_page_replacement verification failed");
    $finish;
  end

  // Queue random references: mostly from a small working set so hits and
  // evictions both happen often, the rest anywhere in the page range.
  task automatic queue_random_refs(input int count);
    logic [InPageW-1:0] pool [6];
    int pool_size;
    int i;
    int k;
    pool_size = 2;
    for (i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        pool_size = $urandom_range(6, 2);
        for (k = 0; k < 6; k++) pool[k] = InPageW'($urandom_range(255, 0));
      end
      if ($urandom_range(99, 0) < 75)
        page_backlog.push_back(pool[$urandom_range(pool_size - 1, 0)]);
      else
        page_backlog.push_back(InPageW'($urandom_range(255, 0)));
    end
  endtask

  // Pause the sender until every queued reference has been taken and answered.
  task automatic wait_drained();
    while (page_backlog.size() != 0 || in_valid_i || outcome_q.size() != 0)
      @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    queue_random_refs(count);
    wait_drained();
  endtask

  initial begin : stimulus
    int i;
    for (i = 0; i < Frames; i++) lru_stack[i] = frame_page_t'(i + 1);
    fault_tally  = '0;
    access_tally = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: hit on the least recent preloaded page, hits in the middle and at
    // the most recent end, page zero and the top page as misses then hits, and
    // alternating bit patterns to toggle every page bit.
    page_backlog = '{8'd1, 8'd3, 8'd3, 8'd0, 8'd255, 8'd0, 8'd255, 8'd2, 8'h80,
                     8'h7F, 8'h55, 8'hAA, 8'h01, 8'hFE, 8'h55, 8'h80, 8'hAA, 8'd0};
    wait_drained();

    // No idling; the receiver holds off for a long stretch so the block fills up
    // and stalls its request channel while the sender keeps offering.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random_refs(300);
    @(posedge clk_i);
    long_hold_req = 1'b1;
    wait_drained();

    run_random_phase(300, 60, 0);
    run_random_phase(300, 0, 60);
    run_random_phase(300, 24, 24);

    // A short closing burst with both sides idling now and then.
    run_random_phase(40, 24, 24);

    repeat (10) @(posedge clk_i);
    if (outcome_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
    if (mismatches == 0) begin
      $display("lru_page_replacement verification clean");
    end else begin
      $display("lru_page_replacement verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/lrupr_pkg.sv
hdl/lrupr_ctrl.sv
hdl/lrupr_dp.sv
hdl/lru_page_replacement.sv
hdl/lrupr_checker.sv
test/tb_top.sv
